/* sv/lgm_pkg.sv */
package lgm_pkg;

  localparam int MAX_CORNERS = 8;
  localparam int SPACE_DIM   = 3;
  localparam int REF_FRAC    = 16;
  localparam int IDX_W       = 3;
  localparam int CLS_W       = 3;

  localparam logic [REF_FRAC:0] REF_ONE = 17'd65536;

  localparam int DIV_STAGES  = 19;
  localparam int LANE_STAGES = 6;
  localparam int LOAD_STAGE  = DIV_STAGES;
  localparam int NUM_STAGES  = 1 + DIV_STAGES + LANE_STAGES;

  localparam logic [CLS_W-1:0] CLS_VERTEX   = 3'd0;
  localparam logic [CLS_W-1:0] CLS_LINE     = 3'd1;
  localparam logic [CLS_W-1:0] CLS_QUAD     = 3'd2;
  localparam logic [CLS_W-1:0] CLS_TRIANGLE = 3'd3;
  localparam logic [CLS_W-1:0] CLS_HEX      = 3'd4;
  localparam logic [CLS_W-1:0] CLS_TET      = 3'd5;
  localparam logic [CLS_W-1:0] CLS_PRISM    = 3'd6;
  localparam logic [CLS_W-1:0] CLS_PYRAMID  = 3'd7;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  typedef logic [REF_FRAC:0] ref_t;
  typedef logic signed [31:0] coord_t;
  typedef logic signed [49:0] prod_t;

  typedef struct packed {
    logic             eval;
    logic             last;
    logic [IDX_W-1:0] idx;
    coord_t           cx;
    coord_t           cy;
    coord_t           cz;
    ref_t             u;
    ref_t             v;
    ref_t             w;
  } item_t;

  function automatic ref_t clamp_ref(input ref_t r);
    return (r > REF_ONE) ? REF_ONE : r;
  endfunction

  function automatic prod_t blend_mul(input coord_t a, input coord_t b, input ref_t t);
    logic signed [32:0] d;
    logic signed [50:0] p;
    d = 33'(b) - 33'(a);
    p = 51'(d) * 51'($signed({1'b0, t}));
    return p[49:0];
  endfunction

  function automatic coord_t round_add(input coord_t a, input prod_t p);
    logic signed [49:0] s;
    logic signed [33:0] r;
    s = p + 50'sd32768;
    r = 34'(a) + $signed(s[49:16]);
    return r[31:0];
  endfunction

  function automatic coord_t sat32(input logic signed [35:0] x);
    coord_t r;
    if (x > 36'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -36'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

/* sv/lgm_in_if.sv */
interface lgm_in_if;
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic [lgm_pkg::IDX_W-1:0]   vertex_index;
  logic signed [31:0]          corner_x;
  logic signed [31:0]          corner_y;
  logic signed [31:0]          corner_z;
  logic [lgm_pkg::REF_FRAC:0]  ref_u;
  logic [lgm_pkg::REF_FRAC:0]  ref_v;
  logic [lgm_pkg::REF_FRAC:0]  ref_w;
  logic                        last_point;

  modport source (
    output valid, command, vertex_index, corner_x, corner_y, corner_z,
           ref_u, ref_v, ref_w, last_point,
    input  ready
  );
  modport sink (
    input  valid, command, vertex_index, corner_x, corner_y, corner_z,
           ref_u, ref_v, ref_w, last_point,
    output ready
  );
endinterface

/* sv/lgm_out_if.sv */
interface lgm_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic               batch_end;

  modport source (output valid, out_x, out_y, out_z, batch_end, input ready);
  modport sink (input valid, out_x, out_y, out_z, batch_end, output ready);
endinterface

/* sv/linear_element_geometry_map.sv */
// Maps reference points (u,v,w, Q1.16) to physical Q16.16 coordinates for the
// configured element class, using corners written by earlier load beats.
// A new beat is taken every cycle unless the result port stalls a full
// pipeline; an evaluate beat reaches the result port through 26 register
// stages: the input register, the 19-stage bit-per-stage divider that
// projects pyramid points onto the base, and six interpolation stages. Load
// beats update the corner store when they reach the end of the divider, so
// every evaluate sees exactly the loads that were accepted before it.
// Write element_class only while no beat is in flight.
module linear_element_geometry_map (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [lgm_pkg::CLS_W-1:0]       cfg_data,
  lgm_in_if.sink                          points,
  lgm_out_if.source                       results
);

  localparam int NS = lgm_pkg::NUM_STAGES;
  localparam int LS = lgm_pkg::LOAD_STAGE;

  logic [lgm_pkg::CLS_W-1:0] element_class;
  logic [NS-1:0] vld;
  logic [NS:0]   en;
  logic [NS-1:LS+1] last;

  lgm_pkg::item_t  s0, sr;
  lgm_pkg::ref_t   bu, bv;
  lgm_pkg::coord_t store [lgm_pkg::SPACE_DIM][lgm_pkg::MAX_CORNERS];
  lgm_pkg::coord_t res [lgm_pkg::SPACE_DIM];

  always_ff @(posedge clk) begin
    if (rst) begin
      element_class <= lgm_pkg::CLS_HEX;
    end else if (cfg_we) begin
      element_class <= cfg_data;
    end
  end

  always_comb begin
    en[NS] = results.ready;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign points.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= points.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          vld[k] <= (k == LS + 1) ? (vld[k-1] && sr.eval) : vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0.eval <= points.command == lgm_pkg::CMD_EVAL;
      s0.last <= points.last_point;
      s0.idx  <= points.vertex_index;
      s0.cx   <= points.corner_x;
      s0.cy   <= points.corner_y;
      s0.cz   <= points.corner_z;
      s0.u    <= lgm_pkg::clamp_ref(points.ref_u);
      s0.v    <= lgm_pkg::clamp_ref(points.ref_v);
      s0.w    <= lgm_pkg::clamp_ref(points.ref_w);
    end
  end

  lgm_proj u_proj (
    .clk      (clk),
    .en       (en[LS:1]),
    .item_in  (s0),
    .item_out (sr),
    .base_u   (bu),
    .base_v   (bv)
  );

  always_ff @(posedge clk) begin
    if (vld[LS] && !sr.eval && en[LS+1]) begin
      store[0][sr.idx] <= sr.cx;
      store[1][sr.idx] <= sr.cy;
      store[2][sr.idx] <= sr.cz;
    end
  end

  always_ff @(posedge clk) begin
    if (en[LS+1]) begin
      last[LS+1] <= sr.last;
    end
    for (int k = LS + 2; k < NS; k++) begin
      if (en[k]) begin
        last[k] <= last[k-1];
      end
    end
  end

  for (genvar d = 0; d < lgm_pkg::SPACE_DIM; d++) begin : g_lane
    lgm_lane u_lane (
      .clk           (clk),
      .en            (en[NS-1:LS+1]),
      .element_class (element_class),
      .c             (store[d]),
      .u             (sr.u),
      .v             (sr.v),
      .w             (sr.w),
      .bu            (bu),
      .bv            (bv),
      .res           (res[d])
    );
  end

  assign results.valid     = vld[NS-1];
  assign results.out_x     = res[0];
  assign results.out_y     = res[1];
  assign results.out_z     = res[2];
  assign results.batch_end = last[NS-1];

endmodule

/* sv/lgm_proj.sv */
module lgm_proj (
  input  logic                              clk,
  input  logic [lgm_pkg::DIV_STAGES-1:0]    en,
  input  lgm_pkg::item_t                    item_in,
  output lgm_pkg::item_t                    item_out,
  output lgm_pkg::ref_t                     base_u,
  output lgm_pkg::ref_t                     base_v
);

  localparam int QBITS = lgm_pkg::REF_FRAC + 1;

  typedef struct packed {
    lgm_pkg::item_t it;
    lgm_pkg::ref_t  den;
    logic [32:0]    ru;
    logic [32:0]    rv;
    logic [QBITS-1:0] qu;
    logic [QBITS-1:0] qv;
    logic           ovu;
    logic           ovv;
  } div_t;

  div_t st [QBITS+1];
  div_t prep;

  always_comb begin
    logic [32:0] nu;
    logic [32:0] nv;
    lgm_pkg::ref_t den;
    den = lgm_pkg::REF_ONE - item_in.w;
    nu = {lgm_pkg::REF_ONE - item_in.u, 16'b0} + {17'b0, den[16:1]};
    nv = {lgm_pkg::REF_ONE - item_in.v, 16'b0} + {17'b0, den[16:1]};
    prep.it  = item_in;
    prep.den = den;
    prep.ru  = nu;
    prep.rv  = nv;
    prep.qu  = '0;
    prep.qv  = '0;
    prep.ovu = {1'b0, nu} >= {den, 17'b0};
    prep.ovv = {1'b0, nv} >= {den, 17'b0};
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      st[0] <= prep;
    end
  end

  for (genvar i = 1; i <= QBITS; i++) begin : g_bit
    div_t nxt;
    always_comb begin
      logic [32:0] du;
      logic [32:0] dv;
      du = {16'b0, st[i-1].den} << (QBITS - i);
      dv = {16'b0, st[i-1].den} << (QBITS - i);
      nxt = st[i-1];
      if (st[i-1].ru >= du) begin
        nxt.ru = st[i-1].ru - du;
        nxt.qu[QBITS-i] = 1'b1;
      end
      if (st[i-1].rv >= dv) begin
        nxt.rv = st[i-1].rv - dv;
        nxt.qv[QBITS-i] = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      if (en[i]) begin
        st[i] <= nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[QBITS+1]) begin
      item_out <= st[QBITS].it;
      base_u <= lgm_pkg::REF_ONE -
                ((st[QBITS].ovu || st[QBITS].qu > lgm_pkg::REF_ONE) ?
                 lgm_pkg::REF_ONE : st[QBITS].qu);
      base_v <= lgm_pkg::REF_ONE -
                ((st[QBITS].ovv || st[QBITS].qv > lgm_pkg::REF_ONE) ?
                 lgm_pkg::REF_ONE : st[QBITS].qv);
    end
  end

endmodule

/* sv/lgm_lane.sv */
module lgm_lane (
  input  logic                                clk,
  input  logic [lgm_pkg::LANE_STAGES-1:0]     en,
  input  logic [lgm_pkg::CLS_W-1:0]           element_class,
  input  lgm_pkg::coord_t                     c [lgm_pkg::MAX_CORNERS],
  input  lgm_pkg::ref_t                       u,
  input  lgm_pkg::ref_t                       v,
  input  lgm_pkg::ref_t                       w,
  input  lgm_pkg::ref_t                       bu,
  input  lgm_pkg::ref_t                       bv,
  output lgm_pkg::coord_t                     res
);

  logic is_prism, is_tet, is_bary, is_tt;
  lgm_pkg::coord_t a [4];
  lgm_pkg::coord_t b [4];
  lgm_pkg::ref_t   tu01, tu2, tu3, tv0, tv1, tw;

  always_comb begin
    is_prism = element_class == lgm_pkg::CLS_PRISM;
    is_tet   = element_class == lgm_pkg::CLS_TET;
    is_tt    = is_tet || element_class == lgm_pkg::CLS_TRIANGLE;
    is_bary  = is_tt || is_prism;
    a[0] = c[0];
    b[0] = is_prism ? c[3] : c[1];
    a[1] = is_bary ? c[1] : c[2];
    b[1] = is_prism ? c[4] : c[3];
    a[2] = is_bary ? c[2] : c[4];
    b[2] = c[5];
    a[3] = is_tt ? c[3] : c[6];
    b[3] = c[7];
    tu01 = '0;
    tu2  = '0;
    tu3  = '0;
    unique case (element_class)
      lgm_pkg::CLS_LINE, lgm_pkg::CLS_QUAD: begin
        tu01 = u;
      end
      lgm_pkg::CLS_HEX: begin
        tu01 = u;
        tu2  = u;
        tu3  = u;
      end
      lgm_pkg::CLS_PRISM: begin
        tu01 = w;
        tu2  = w;
      end
      lgm_pkg::CLS_PYRAMID: begin
        tu01 = bu;
      end
      default: begin
        tu01 = '0;
      end
    endcase
  end

  lgm_pkg::coord_t ua [4];
  lgm_pkg::prod_t  up [4];
  lgm_pkg::ref_t   u1u, u1v, u1w, u1bv;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ua[0] <= a[0];
      ua[1] <= a[1];
      ua[2] <= a[2];
      ua[3] <= a[3];
      up[0] <= lgm_pkg::blend_mul(a[0], b[0], tu01);
      up[1] <= lgm_pkg::blend_mul(a[1], b[1], tu01);
      up[2] <= lgm_pkg::blend_mul(a[2], b[2], tu2);
      up[3] <= lgm_pkg::blend_mul(a[3], b[3], tu3);
      u1u <= u;
      u1v <= v;
      u1w <= w;
      u1bv <= bv;
    end
  end

  lgm_pkg::coord_t l [4];
  lgm_pkg::ref_t   u2u, u2v, u2w, u2bv;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < 4; i++) begin
        l[i] <= lgm_pkg::round_add(ua[i], up[i]);
      end
      u2u <= u1u;
      u2v <= u1v;
      u2w <= u1w;
      u2bv <= u1bv;
    end
  end

  always_comb begin
    tv0 = '0;
    tv1 = '0;
    tw  = '0;
    unique case (element_class)
      lgm_pkg::CLS_QUAD: begin
        tv0 = u2v;
      end
      lgm_pkg::CLS_HEX: begin
        tv0 = u2v;
        tv1 = u2v;
        tw  = u2w;
      end
      lgm_pkg::CLS_PYRAMID: begin
        tv0 = u2bv;
        tw  = u2w;
      end
      default: begin
        tv0 = '0;
      end
    endcase
  end

  lgm_pkg::coord_t va0, va1, ba;
  lgm_pkg::prod_t  vp0, vp1, bp1, bp2, bp3;
  lgm_pkg::ref_t   v1tw;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      va0 <= l[0];
      va1 <= l[2];
      vp0 <= lgm_pkg::blend_mul(l[0], l[1], tv0);
      vp1 <= lgm_pkg::blend_mul(l[2], l[3], tv1);
      ba  <= l[0];
      bp1 <= lgm_pkg::blend_mul(l[0], l[1], u2u);
      bp2 <= is_tet ? lgm_pkg::blend_mul(l[2], l[3], u2v)
                    : lgm_pkg::blend_mul(l[1], l[2], u2v);
      bp3 <= lgm_pkg::blend_mul(l[1], l[2], is_tet ? u2w : '0);
      v1tw <= tw;
    end
  end

  lgm_pkg::coord_t m0, m1;
  logic signed [35:0] br;
  lgm_pkg::ref_t   v2tw;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      logic signed [51:0] acc;
      logic signed [51:0] s;
      acc = $signed({{4{ba[31]}}, ba, 16'b0}) + 52'(bp1) + 52'(bp2) + 52'(bp3);
      s = acc + 52'sd32768;
      m0 <= lgm_pkg::round_add(va0, vp0);
      m1 <= lgm_pkg::round_add(va1, vp1);
      br <= $signed(s[51:16]);
      v2tw <= v1tw;
    end
  end

  lgm_pkg::coord_t wa;
  lgm_pkg::prod_t  wp;
  logic signed [35:0] wbr;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      wa  <= m0;
      wp  <= lgm_pkg::blend_mul(m0, m1, v2tw);
      wbr <= br;
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      res <= is_bary ? lgm_pkg::sat32(wbr) : lgm_pkg::round_add(wa, wp);
    end
  end

endmodule
